// ===== rtl/clnw_pkg.sv =====
package clnw_pkg;

    // Operation codes carried in the mode field of an input item.
    typedef enum logic [1:0] {
        MODE_CHAR      = 2'd0,
        MODE_SET_POS   = 2'd1,
        MODE_COMMAND   = 2'd2,
        MODE_BACKLIGHT = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam logic CFG_LAST_COLUMN = 1'b0;
    localparam logic CFG_LAST_LINE   = 1'b1;

    localparam logic [5:0] LAST_COLUMN_RESET = 6'd15;
    localparam logic [1:0] LAST_LINE_RESET   = 2'd1;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] DDRAM_CMD = 8'h80;

    // Byte index of the final byte for one send and for two sends.
    localparam logic [2:0] END_ONE_SEND  = 3'd3;
    localparam logic [2:0] END_TWO_SENDS = 3'd7;

    // DDRAM base address of each display line.
    function automatic logic [6:0] line_base(input logic [1:0] ln);
        logic [6:0] base;
        case (ln)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

    // Set-DDRAM-address command for a column and line; the address wraps at 7 bits.
    function automatic logic [7:0] ddram_command(input logic [5:0] col, input logic [1:0] ln);
        logic [6:0] addr;
        addr = line_base(ln) + {1'b0, col};
        return DDRAM_CMD | {1'b0, addr};
    endfunction

    // Output job built from one input item.
    typedef struct packed {
        logic       emit;      // item produces bytes
        logic       single;    // one backlight-only byte
        logic [2:0] end_idx;   // index of the final byte
        logic [7:0] val0;      // first byte to send
        logic       rs0;       // register select of the first send
        logic [7:0] val1;      // second byte to send (always a command)
        logic       bl;        // backlight bit for every byte of the job
    } t_job;

    // Cursor and backlight state.
    typedef struct packed {
        logic [5:0] col;
        logic [1:0] ln;
        logic       bl;
    } t_cursor;

endpackage

// ===== rtl/char_lcd_i2c_nibble_writer.sv =====
// Latency: the first bus byte of an item is offered in the cycle after the item is accepted.
// Throughput: one bus byte per cycle while i_m_tready is high; an item produces 1, 4 or 8
// bytes, and the next item is taken in the cycle its final byte leaves.
// A set-position item that is out of range produces nothing.
// Reset (synchronous, active low) clears the cursor, turns the backlight on and loads
// last_column = 15, last_line = 1.
module char_lcd_i2c_nibble_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // mode[1:0], data_byte[9:2], column[15:10], line[17:16]
    // Result items.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // bus_byte[7:0]
    output logic        o_m_tlast,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);
    import clnw_pkg::*;

    logic [5:0] r_last_column, n_last_column;
    logic [1:0] r_last_line, n_last_line;
    t_cursor    r_cur, n_cur, dec_cur;
    t_job       r_job, n_job, dec_job;
    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;

    logic       s_accept;
    logic       m_accept;
    logic       at_end;
    logic [7:0] send_val;
    logic       send_rs;
    logic [3:0] nibble;

    clnw_decode u_decode (
        .i_mode        (i_s_tdata[1:0]),
        .i_data_byte   (i_s_tdata[9:2]),
        .i_column      (i_s_tdata[15:10]),
        .i_line        (i_s_tdata[17:16]),
        .i_last_column (r_last_column),
        .i_last_line   (r_last_line),
        .i_cur         (r_cur),
        .o_cur         (dec_cur),
        .o_job         (dec_job)
    );

    // Handshakes: a new item enters when idle or when the job drains its final byte.
    assign at_end     = (r_idx == r_job.end_idx);
    assign m_accept   = o_m_tvalid && i_m_tready;
    assign o_s_tready = !r_busy || (m_accept && at_end);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Byte generator: high nibble then low nibble, enable high then low.
    assign send_val = r_idx[2] ? r_job.val1 : r_job.val0;
    assign send_rs  = r_idx[2] ? 1'b0 : r_job.rs0;
    assign nibble   = r_idx[1] ? send_val[3:0] : send_val[7:4];

    always_comb begin
        o_m_tvalid = r_busy;
        o_m_tlast  = at_end;
        if (r_job.single) begin
            o_m_tdata = {4'd0, r_job.bl, 3'd0};
        end else begin
            o_m_tdata = {nibble, r_job.bl, !r_idx[0], 1'b0, send_rs};
        end
    end

    // Next state of the job, cursor and configuration.
    always_comb begin
        n_last_column = r_last_column;
        n_last_line   = r_last_line;
        n_cur         = r_cur;
        n_job         = r_job;
        n_busy        = r_busy;
        n_idx         = r_idx;
        if (i_cfg_valid) begin
            if (i_cfg_addr == CFG_LAST_COLUMN) begin
                n_last_column = i_cfg_data[5:0];
            end else begin
                n_last_line = i_cfg_data[1:0];
            end
        end
        if (m_accept) begin
            n_idx = r_idx + 3'd1;
            if (at_end) begin
                n_busy = 1'b0;
            end
        end
        if (s_accept) begin
            n_cur  = dec_cur;
            n_job  = dec_job;
            n_busy = dec_job.emit;
            n_idx  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_column <= LAST_COLUMN_RESET;
            r_last_line   <= LAST_LINE_RESET;
            r_cur         <= '{col: 6'd0, ln: 2'd0, bl: 1'b1};
            r_busy        <= 1'b0;
            r_idx         <= 3'd0;
        end else begin
            r_last_column <= n_last_column;
            r_last_line   <= n_last_line;
            r_cur         <= n_cur;
            r_busy        <= n_busy;
            r_idx         <= n_idx;
        end
    end

    // Job payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

// ===== rtl/clnw_decode.sv =====
module clnw_decode (
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_data_byte,
    input  logic [5:0]       i_column,
    input  logic [1:0]       i_line,
    input  logic [5:0]       i_last_column,
    input  logic [1:0]       i_last_line,
    input  clnw_pkg::t_cursor i_cur,
    output clnw_pkg::t_cursor o_cur,
    output clnw_pkg::t_job    o_job
);
    import clnw_pkg::*;

    logic       wrap;
    logic [1:0] wrap_line;

    // Cursor wrap after a character in the last column.
    assign wrap      = (i_cur.col >= i_last_column);
    assign wrap_line = (i_cur.ln >= i_last_line) ? 2'd0 : i_cur.ln + 2'd1;

    // Build the job and the next cursor for each operation.
    always_comb begin
        o_cur          = i_cur;
        o_job.emit     = 1'b1;
        o_job.single   = 1'b0;
        o_job.end_idx  = END_ONE_SEND;
        o_job.val0     = i_data_byte;
        o_job.rs0      = 1'b0;
        o_job.val1     = ddram_command(6'd0, wrap_line);
        o_job.bl       = i_cur.bl;
        case (t_mode'(i_mode))
            MODE_CHAR: begin
                o_job.rs0 = 1'b1;
                if (wrap) begin
                    o_job.end_idx = END_TWO_SENDS;
                    o_cur.col     = 6'd0;
                    o_cur.ln      = wrap_line;
                end else begin
                    o_cur.col = i_cur.col + 6'd1;
                end
            end
            MODE_SET_POS: begin
                o_job.val0 = ddram_command(i_column, i_line);
                if (i_column > i_last_column || i_line > i_last_line) begin
                    o_job.emit = 1'b0;
                end else begin
                    o_cur.col = i_column;
                    o_cur.ln  = i_line;
                end
            end
            MODE_COMMAND: begin
                if (i_data_byte == CMD_CLEAR || i_data_byte == CMD_HOME) begin
                    o_cur.col = 6'd0;
                    o_cur.ln  = 2'd0;
                end
            end
            default: begin
                o_cur.bl      = i_data_byte[0];
                o_job.bl      = i_data_byte[0];
                o_job.single  = 1'b1;
                o_job.end_idx = 3'd0;
            end
        endcase
    end

endmodule

// ===== rtl/clnw_checker.sv =====
module clnw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A stalled result holds its byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result byte changed while stalled");

    // Bit 1 of every bus byte is zero.
    a_bit1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[1])
        else $error("bus byte bit 1 set");

    // A strobe byte is never the final byte of an item.
    a_no_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tlast)
        else $error("enable-high byte marked last");

    // The byte after a strobe is the same byte with enable low, offered at once.
    a_strobe_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tdata[2] |=>
            o_m_tvalid && o_m_tdata == ($past(o_m_tdata) & 8'hFB))
        else $error("enable-low byte does not follow strobe");

endmodule

bind char_lcd_i2c_nibble_writer clnw_checker u_clnw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
